// ----- rtl/core/sit_pkg.sv -----
package sit_pkg;

   localparam int TABLE_DEPTH_DEF = 64;

   localparam int OPCODE_W = 1;
   localparam int SYMBOL_W = 8;
   localparam int LOOKUP_W = 8;
   localparam int INDEX_W  = 6;
   localparam int COUNT_W  = 7;

   localparam logic [OPCODE_W-1:0] OP_INTERN  = 1'b0;
   localparam logic [OPCODE_W-1:0] OP_REVERSE = 1'b1;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SCAN  = 5'b00010,
      ST_RREAD = 5'b00100,
      ST_MISS  = 5'b01000,
      ST_EMIT  = 5'b10000
   } sit_state_type;

   typedef struct packed {
      logic [INDEX_W-1:0]  index;
      logic [SYMBOL_W-1:0] symbol_code;
      logic                found;
      logic                inserted;
      logic                full_res;
      logic [COUNT_W-1:0]  entry_count;
   } sit_result_type;

endpackage

// ----- rtl/core/sit_mem.sv -----
module sit_mem #(
   parameter int DEPTH = sit_pkg::TABLE_DEPTH_DEF,
   parameter int AW    = $clog2(sit_pkg::TABLE_DEPTH_DEF)
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [AW-1:0]               wr_addr,
   input  logic [sit_pkg::SYMBOL_W-1:0] wr_data,
   input  logic [AW-1:0]               rd_addr,
   output logic [sit_pkg::SYMBOL_W-1:0] rd_data
);

   logic [sit_pkg::SYMBOL_W-1:0] store_ff [DEPTH];
   logic [sit_pkg::SYMBOL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/sit_ctrl.sv -----
module sit_ctrl #(
   parameter int TABLE_DEPTH = sit_pkg::TABLE_DEPTH_DEF,
   parameter int AW          = $clog2(sit_pkg::TABLE_DEPTH_DEF),
   parameter int CW          = $clog2(sit_pkg::TABLE_DEPTH_DEF + 1)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [sit_pkg::OPCODE_W-1:0] req_opcode,
   input  logic [sit_pkg::SYMBOL_W-1:0] req_symbol,
   input  logic [sit_pkg::LOOKUP_W-1:0] req_lookup_index,
   output logic                         res_valid,
   input  logic                         res_ready,
   output sit_pkg::sit_result_type      res,
   output logic                         wr_en,
   output logic [AW-1:0]                wr_addr,
   output logic [sit_pkg::SYMBOL_W-1:0] wr_data,
   output logic [AW-1:0]                rd_addr,
   input  logic [sit_pkg::SYMBOL_W-1:0] rd_data
);

   localparam int CMP_W = 9;

   sit_pkg::sit_state_type state_ff, state_in;
   logic [CW-1:0]                count_ff, count_in;
   logic [AW-1:0]                ptr_ff, ptr_in;
   logic [sit_pkg::SYMBOL_W-1:0] sym_ff, sym_in;
   logic [sit_pkg::LOOKUP_W-1:0] lidx_ff, lidx_in;
   logic [sit_pkg::INDEX_W-1:0]  r_index_ff, r_index_in;
   logic [sit_pkg::SYMBOL_W-1:0] r_code_ff, r_code_in;
   logic                         r_found_ff, r_found_in;
   logic                         r_ins_ff, r_ins_in;
   logic                         r_full_ff, r_full_in;

   logic accept;
   logic lidx_in_range;
   logic scan_last;
   logic has_room;

   assign accept        = req_valid && req_ready;
   assign lidx_in_range = CMP_W'(req_lookup_index) < CMP_W'(count_ff);
   assign scan_last     = (CW'(ptr_ff) + CW'(1)) == count_ff;
   assign has_room      = count_ff < CW'(TABLE_DEPTH);

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      ptr_in     = ptr_ff;
      sym_in     = sym_ff;
      lidx_in    = lidx_ff;
      r_index_in = r_index_ff;
      r_code_in  = r_code_ff;
      r_found_in = r_found_ff;
      r_ins_in   = r_ins_ff;
      r_full_in  = r_full_ff;
      wr_en      = 1'b0;
      wr_addr    = count_ff[AW-1:0];
      wr_data    = sym_ff;
      rd_addr    = ptr_ff + AW'(1);
      req_ready  = 1'b0;
      res_valid  = 1'b0;

      unique case (state_ff)
         sit_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            rd_addr   = (req_opcode == sit_pkg::OP_REVERSE) ?
                        req_lookup_index[AW-1:0] : '0;
            if (accept) begin
               sym_in     = req_symbol;
               lidx_in    = req_lookup_index;
               ptr_in     = '0;
               r_index_in = '0;
               r_code_in  = '0;
               r_found_in = 1'b0;
               r_ins_in   = 1'b0;
               r_full_in  = 1'b0;
               if (req_opcode == sit_pkg::OP_REVERSE) begin
                  state_in = lidx_in_range ? sit_pkg::ST_RREAD : sit_pkg::ST_EMIT;
               end else begin
                  state_in = (count_ff == '0) ? sit_pkg::ST_MISS : sit_pkg::ST_SCAN;
               end
            end
         end
         sit_pkg::ST_SCAN: begin
            if (rd_data == sym_ff) begin
               r_found_in = 1'b1;
               r_index_in = sit_pkg::INDEX_W'(ptr_ff);
               state_in   = sit_pkg::ST_EMIT;
            end else if (scan_last) begin
               state_in = sit_pkg::ST_MISS;
            end else begin
               ptr_in = ptr_ff + AW'(1);
            end
         end
         sit_pkg::ST_RREAD: begin
            r_found_in = 1'b1;
            r_index_in = sit_pkg::INDEX_W'(lidx_ff);
            r_code_in  = rd_data;
            state_in   = sit_pkg::ST_EMIT;
         end
         sit_pkg::ST_MISS: begin
            if (has_room) begin
               wr_en      = 1'b1;
               r_ins_in   = 1'b1;
               r_index_in = sit_pkg::INDEX_W'(count_ff);
               count_in   = count_ff + CW'(1);
            end else begin
               r_full_in = 1'b1;
            end
            state_in = sit_pkg::ST_EMIT;
         end
         sit_pkg::ST_EMIT: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = sit_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sit_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sit_pkg::ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff     <= ptr_in;
      sym_ff     <= sym_in;
      lidx_ff    <= lidx_in;
      r_index_ff <= r_index_in;
      r_code_ff  <= r_code_in;
      r_found_ff <= r_found_in;
      r_ins_ff   <= r_ins_in;
      r_full_ff  <= r_full_in;
   end

   assign res.index       = r_index_ff;
   assign res.symbol_code = r_code_ff;
   assign res.found       = r_found_ff;
   assign res.inserted    = r_ins_ff;
   assign res.full_res    = r_full_ff;
   assign res.entry_count = sit_pkg::COUNT_W'(count_ff);

endmodule

// ----- rtl/core/symbol_intern_table.sv -----
// channel   handshake              payload
// req       req_valid/req_ready    req_opcode, req_symbol, req_lookup_index
// rsp       rsp_valid/rsp_ready    rsp_index, rsp_symbol_code, rsp_found,
//                                  rsp_inserted, rsp_full_res, rsp_entry_count
//
// one request at a time; the symbol memory scan reads one stored entry per cycle
// intern hit at index k: scan entries 0 to k, then emit; intern miss: scan every stored entry,
// then insert (or report full) and emit; reverse lookup: read, then emit, or emit at once when out of range
// reset clears the state machine, the count and the response valid flag only
// a stalled response sits in the output register while the next request runs
module symbol_intern_table #(
   parameter int TABLE_DEPTH = sit_pkg::TABLE_DEPTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [sit_pkg::OPCODE_W-1:0] req_opcode,
   input  logic [sit_pkg::SYMBOL_W-1:0] req_symbol,
   input  logic [sit_pkg::LOOKUP_W-1:0] req_lookup_index,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [sit_pkg::INDEX_W-1:0]  rsp_index,
   output logic [sit_pkg::SYMBOL_W-1:0] rsp_symbol_code,
   output logic                         rsp_found,
   output logic                         rsp_inserted,
   output logic                         rsp_full_res,
   output logic [sit_pkg::COUNT_W-1:0]  rsp_entry_count
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   logic                         wr_en;
   logic [AW-1:0]                wr_addr;
   logic [sit_pkg::SYMBOL_W-1:0] wr_data;
   logic [AW-1:0]                rd_addr;
   logic [sit_pkg::SYMBOL_W-1:0] rd_data;
   logic                         res_valid;
   logic                         res_ready;
   sit_pkg::sit_result_type      res;

   logic                         rsp_valid_ff, rsp_valid_in;
   sit_pkg::sit_result_type      rsp_ff, rsp_in;

   sit_mem #(
      .DEPTH (TABLE_DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   sit_ctrl #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .AW          (AW),
      .CW          (CW)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_symbol       (req_symbol),
      .req_lookup_index (req_lookup_index),
      .res_valid        (res_valid),
      .res_ready        (res_ready),
      .res              (res),
      .wr_en            (wr_en),
      .wr_addr          (wr_addr),
      .wr_data          (wr_data),
      .rd_addr          (rd_addr),
      .rd_data          (rd_data)
   );

   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_index       = rsp_ff.index;
   assign rsp_symbol_code = rsp_ff.symbol_code;
   assign rsp_found       = rsp_ff.found;
   assign rsp_inserted    = rsp_ff.inserted;
   assign rsp_full_res    = rsp_ff.full_res;
   assign rsp_entry_count = rsp_ff.entry_count;

endmodule

// ----- rtl/core/sit_checker.sv -----
module sit_checker #(
   parameter int TABLE_DEPTH = sit_pkg::TABLE_DEPTH_DEF
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [sit_pkg::INDEX_W-1:0]  rsp_index,
   input logic [sit_pkg::SYMBOL_W-1:0] rsp_symbol_code,
   input logic                         rsp_found,
   input logic                         rsp_inserted,
   input logic                         rsp_full_res,
   input logic [sit_pkg::COUNT_W-1:0]  rsp_entry_count
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_index)
         && $stable(rsp_symbol_code) && $stable(rsp_entry_count))
      else $error("response changed while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous one in progress");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_found && rsp_inserted) && !(rsp_found && rsp_full_res)
         && !(rsp_inserted && rsp_full_res))
      else $error("conflicting result flags");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_full_res |-> rsp_entry_count == sit_pkg::COUNT_W'(TABLE_DEPTH))
      else $error("full reported below capacity");

   a_insert_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_inserted
         |-> rsp_index == sit_pkg::INDEX_W'(rsp_entry_count - sit_pkg::COUNT_W'(1)))
      else $error("inserted index is not the last entry");

endmodule

bind symbol_intern_table sit_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_sit_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_index       (rsp_index),
   .rsp_symbol_code (rsp_symbol_code),
   .rsp_found       (rsp_found),
   .rsp_inserted    (rsp_inserted),
   .rsp_full_res    (rsp_full_res),
   .rsp_entry_count (rsp_entry_count)
);

// ----- tb/sv/symbol_intern_table_tb.sv -----
module symbol_intern_table_tb;
   import sit_pkg::*;

   localparam int TABLE_DEPTH = TABLE_DEPTH_DEF;
   localparam int RANDOM_REQS = 1850;
   localparam int CYCLE_LIMIT = 2000000;

   typedef struct packed {
      logic [OPCODE_W-1:0] opcode;
      logic [SYMBOL_W-1:0] symbol;
      logic [LOOKUP_W-1:0] lookup_index;
   } intern_req_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [OPCODE_W-1:0] req_opcode = OP_INTERN;
   logic [SYMBOL_W-1:0] req_symbol = '0;
   logic [LOOKUP_W-1:0] req_lookup_index = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [INDEX_W-1:0]  rsp_index;
   logic [SYMBOL_W-1:0] rsp_symbol_code;
   logic                rsp_found;
   logic                rsp_inserted;
   logic                rsp_full_res;
   logic [COUNT_W-1:0]  rsp_entry_count;

   intern_req_type pending_req[$];
   sit_result_type awaited_rsp[$];

   // predicted table contents
   logic [SYMBOL_W-1:0] tbl_sym[TABLE_DEPTH];
   int                  tbl_count = 0;

   // stimulus-side view of which symbols are interned
   bit                  gen_seen[256];
   logic [SYMBOL_W-1:0] gen_syms[$];

   int fail_count = 0;
   int rsp_seen = 0;
   int cycles = 0;
   int req_gap = 0;
   int req_calm = 0;
   int rsp_stall = 0;
   int rsp_calm = 0;

   symbol_intern_table u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_opcode       (req_opcode),
      .req_symbol       (req_symbol),
      .req_lookup_index (req_lookup_index),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_index        (rsp_index),
      .rsp_symbol_code  (rsp_symbol_code),
      .rsp_found        (rsp_found),
      .rsp_inserted     (rsp_inserted),
      .rsp_full_res     (rsp_full_res),
      .rsp_entry_count  (rsp_entry_count)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic sit_result_type intern_step(intern_req_type rq);
      sit_result_type r;
      bit             hit;
      int             i;
      r = '0;
      hit = 1'b0;
      if (rq.opcode == OP_INTERN) begin
         for (i = 0; i < tbl_count; i++) begin
            if (!hit && tbl_sym[i] == rq.symbol) begin
               hit = 1'b1;
               r.index = i[INDEX_W-1:0];
            end
         end
         if (hit) begin
            r.found = 1'b1;
         end else if (tbl_count < TABLE_DEPTH) begin
            tbl_sym[tbl_count] = rq.symbol;
            r.index = tbl_count[INDEX_W-1:0];
            r.inserted = 1'b1;
            tbl_count++;
         end else begin
            r.full_res = 1'b1;
         end
      end else if (rq.lookup_index < tbl_count) begin
         r.found = 1'b1;
         r.index = rq.lookup_index[INDEX_W-1:0];
         r.symbol_code = tbl_sym[rq.lookup_index];
      end
      r.entry_count = tbl_count[COUNT_W-1:0];
      return r;
   endfunction

   function automatic int draw_pause();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 96) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   task automatic queue_req(logic [OPCODE_W-1:0] op, logic [SYMBOL_W-1:0] sym,
                            logic [LOOKUP_W-1:0] lidx);
      intern_req_type rq;
      rq.opcode = op;
      rq.symbol = sym;
      rq.lookup_index = lidx;
      pending_req.push_back(rq);
      if (op == OP_INTERN && !gen_seen[sym] && gen_syms.size() < TABLE_DEPTH) begin
         gen_seen[sym] = 1'b1;
         gen_syms.push_back(sym);
      end
   endtask

   task automatic report_mismatch(string msg);
      $display("rsp %0d: %s", rsp_seen, msg);
      fail_count++;
   endtask

   task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
   endtask

   // request driver
   always @(posedge clock) begin : p_driver
      intern_req_type rq;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_gap > 0) begin
            req_gap--;
            req_valid <= 1'b0;
         end else if (pending_req.size() > 0) begin
            rq = pending_req.pop_front();
            req_opcode <= rq.opcode;
            req_symbol <= rq.symbol;
            req_lookup_index <= rq.lookup_index;
            req_valid <= 1'b1;
            if (req_calm > 0) begin
               req_calm--;
            end else if ($urandom_range(0, 99) < 3) begin
               req_calm = $urandom_range(20, 60);
            end else begin
               req_gap = draw_pause();
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response backpressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (rsp_calm > 0) begin
            rsp_calm--;
         end else if ($urandom_range(0, 99) < 3) begin
            rsp_calm = $urandom_range(20, 60);
         end else if ($urandom_range(0, 99) < 40) begin
            rsp_stall = draw_pause();
         end
      end
   end

   // monitor: responses checked before the new request is predicted
   always @(posedge clock) begin : p_monitor
      sit_result_type want;
      intern_req_type rq;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            rsp_seen++;
            if (awaited_rsp.size() == 0) begin
               report_mismatch("response with none outstanding");
            end else begin
               want = awaited_rsp.pop_front();
               check_field("index", 32'(rsp_index), 32'(want.index));
               check_field("symbol_code", 32'(rsp_symbol_code), 32'(want.symbol_code));
               check_field("found", 32'(rsp_found), 32'(want.found));
               check_field("inserted", 32'(rsp_inserted), 32'(want.inserted));
               check_field("full_res", 32'(rsp_full_res), 32'(want.full_res));
               check_field("entry_count", 32'(rsp_entry_count), 32'(want.entry_count));
            end
         end
         if (req_valid && req_ready) begin
            rq.opcode = req_opcode;
            rq.symbol = req_symbol;
            rq.lookup_index = req_lookup_index;
            awaited_rsp.push_back(intern_step(rq));
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("symbol_intern_table: mismatch");
         $finish;
      end
   end

   initial begin : p_stimulus
      int                  k;
      int                  n;
      int                  pick;
      logic [LOOKUP_W-1:0] lidx;
      logic [SYMBOL_W-1:0] sym;

      // empty table, boundaries, hits, out-of-range reverse lookups
      queue_req(OP_REVERSE, 8'hFF, 8'h00);
      queue_req(OP_INTERN, 8'h00, 8'h00);
      queue_req(OP_INTERN, 8'hFF, 8'hFF);
      queue_req(OP_INTERN, 8'h00, 8'hFF);
      queue_req(OP_INTERN, 8'hFF, 8'h00);
      queue_req(OP_REVERSE, 8'h00, 8'h00);
      queue_req(OP_REVERSE, 8'hFF, 8'h01);
      queue_req(OP_REVERSE, 8'h00, 8'h02);
      queue_req(OP_REVERSE, 8'h00, 8'hFF);
      queue_req(OP_REVERSE, 8'h00, 8'h80);
      queue_req(OP_INTERN, 8'h80, 8'h00);
      queue_req(OP_INTERN, 8'h01, 8'h00);
      queue_req(OP_INTERN, 8'h7F, 8'h00);
      queue_req(OP_INTERN, 8'hAA, 8'h55);
      queue_req(OP_INTERN, 8'h55, 8'hAA);
      queue_req(OP_REVERSE, 8'hAA, 8'h06);
      queue_req(OP_REVERSE, 8'h55, 8'h07);
      queue_req(OP_INTERN, 8'h55, 8'h3F);
      queue_req(OP_REVERSE, 8'h00, 8'h03);

      // table fills gradually, then stays full
      for (k = 0; k < RANDOM_REQS; k++) begin
         n = gen_syms.size();
         if ($urandom_range(0, 99) < 40) begin
            pick = int'($urandom_range(0, 9));
            if (pick < 6 && n > 0) lidx = LOOKUP_W'($urandom_range(0, n - 1));
            else if (pick < 8) lidx = LOOKUP_W'(n + int'($urandom_range(0, 2)));
            else lidx = LOOKUP_W'($urandom_range(0, 255));
            queue_req(OP_REVERSE, SYMBOL_W'($urandom_range(0, 255)), lidx);
         end else begin
            if (n == 0 || $urandom_range(0, 99) < (n < TABLE_DEPTH ? 15 : 40))
               sym = SYMBOL_W'($urandom_range(0, 255));
            else
               sym = gen_syms[$urandom_range(0, n - 1)];
            queue_req(OP_INTERN, sym, LOOKUP_W'($urandom_range(0, 255)));
         end
      end

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (pending_req.size() > 0 || req_valid) @(posedge clock);
      while (awaited_rsp.size() > 0) @(posedge clock);
      repeat (TABLE_DEPTH + 8) @(posedge clock);

      if (fail_count == 0) begin
         $display("symbol_intern_table: match");
      end else begin
         $display("symbol_intern_table: mismatch");
      end
      $finish;
   end

endmodule
